### hdl/nvp_pkg.sv
// ----------------------------------------------------------------------------
// nvp_pkg
// Shared constants, field codes and types of the navigation frame parser.
// ----------------------------------------------------------------------------
package nvp_pkg;

  localparam int unsigned PosW        = 7;
  localparam int unsigned FrameLen    = 100;
  localparam int unsigned LastPos     = FrameLen - 1;
  localparam int unsigned SumFirstPos = 2;
  localparam int unsigned SumCount    = 96;
  localparam int unsigned SumLastPos  = SumFirstPos + SumCount - 1;

  localparam int unsigned OffMonth   = 12;
  localparam int unsigned OffDay     = 13;
  localparam int unsigned OffHour    = 14;
  localparam int unsigned OffMinute  = 15;
  localparam int unsigned OffSecond  = 16;
  localparam int unsigned OffValid   = 17;
  localparam int unsigned OffFixType = 26;
  localparam int unsigned OffSats    = 29;
  localparam int unsigned OffLon     = 30;
  localparam int unsigned OffLat     = 34;
  localparam int unsigned OffAlt     = 42;
  localparam int unsigned OffSpeed   = 66;
  localparam int unsigned OffDopLo   = 82;
  localparam int unsigned OffDopHi   = 83;
  localparam int unsigned OffHeading = 90;
  localparam int unsigned OffTrailer = 98;

  localparam int unsigned NumSmall  = 8;
  localparam int unsigned NumFields = 14;
  localparam int unsigned CodeW     = 4;
  localparam int unsigned ValW      = 32;
  localparam int unsigned DopW      = 16;

  localparam logic [CodeW-1:0] FldMonth   = 4'd0;
  localparam logic [CodeW-1:0] FldDay     = 4'd1;
  localparam logic [CodeW-1:0] FldHour    = 4'd2;
  localparam logic [CodeW-1:0] FldMinute  = 4'd3;
  localparam logic [CodeW-1:0] FldSecond  = 4'd4;
  localparam logic [CodeW-1:0] FldValid   = 4'd5;
  localparam logic [CodeW-1:0] FldFixType = 4'd6;
  localparam logic [CodeW-1:0] FldSats    = 4'd7;
  localparam logic [CodeW-1:0] FldLon     = 4'd8;
  localparam logic [CodeW-1:0] FldLat     = 4'd9;
  localparam logic [CodeW-1:0] FldAlt     = 4'd10;
  localparam logic [CodeW-1:0] FldSpeed   = 4'd11;
  localparam logic [CodeW-1:0] FldDop     = 4'd12;
  localparam logic [CodeW-1:0] FldHeading = 4'd13;

  // Division by 1000 is a shift by 3 and a reciprocal multiply for 125.
  localparam int unsigned KiloShift = 3;
  localparam int unsigned KiloNW    = ValW - KiloShift;
  localparam int unsigned KiloMulW  = 30;
  localparam logic [KiloMulW-1:0] KiloMul = 30'd549755814;
  localparam int unsigned KiloK     = 36;
  localparam int unsigned KiloQW    = KiloNW + KiloMulW - KiloK;

  // Division by 100000 is a shift by 5 and a reciprocal multiply for 3125.
  localparam int unsigned HdgShift = 5;
  localparam int unsigned HdgNW    = ValW - HdgShift;
  localparam int unsigned HdgMulW  = 28;
  localparam logic [HdgMulW-1:0] HdgMul = 28'd175921861;
  localparam int unsigned HdgK     = 39;
  localparam int unsigned HdgQW    = HdgNW + HdgMulW - HdgK;

  // Division by 100 is a shift by 2 and a reciprocal multiply for 25.
  localparam int unsigned DopShift = 2;
  localparam int unsigned DopNW    = DopW - DopShift;
  localparam int unsigned DopMulW  = 15;
  localparam logic [DopMulW-1:0] DopMul = 15'd20972;
  localparam int unsigned DopK     = 19;
  localparam int unsigned DopQW    = DopNW + DopMulW - DopK;

  typedef struct packed {
    logic [NumSmall-1:0][7:0] octets;
    logic [ValW-1:0]          lon;
    logic [ValW-1:0]          lat;
    logic [ValW-1:0]          alt;
    logic [ValW-1:0]          speed;
    logic [ValW-1:0]          heading;
    logic [DopW-1:0]          dop;
    logic                     good;
  } frame_t;

  typedef struct packed {
    logic [NumFields-1:0][ValW-1:0] vals;
    logic                           good;
  } result_t;

endpackage

### hdl/nvp_accum.sv
// ----------------------------------------------------------------------------
// nvp_accum
// Byte position tracking, Fletcher checksum and field capture of one frame.
// ----------------------------------------------------------------------------
module nvp_accum (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             frame_byte_i,
  input  logic                   frame_start_i,
  input  logic                   hold_i,
  output logic                   done_o,
  output nvp_pkg::frame_t        frame_o
);
  import nvp_pkg::*;

  logic                      rx_on_q;
  logic [PosW-1:0]           pos_q, pos_d;
  logic [PosW-1:0]           p_eff;
  logic [PosW-1:0]           lane_lon, lane_lat, lane_alt, lane_spd, lane_hdg;
  logic                      accept, take;
  logic [7:0]                sum_first_q, sum_second_q, trailer_q, first_new;
  logic [NumSmall-1:0][7:0]  small_q;
  logic [ValW-1:0]           lon_q, lat_q, alt_q, spd_q, hdg_q;
  logic [DopW-1:0]           dop_q;

  function automatic logic in_word(logic [PosW-1:0] pos, int unsigned off);
    return (pos >= PosW'(off)) && (pos < PosW'(off + 4));
  endfunction

  assign in_ready_o = !(hold_i && (pos_q == PosW'(LastPos)));
  assign accept     = in_valid_i && in_ready_o && rx_on_q;
  assign p_eff      = frame_start_i ? '0 : pos_q;
  assign take       = accept && (p_eff < PosW'(FrameLen));
  assign done_o     = take && (p_eff == PosW'(LastPos));
  assign first_new  = sum_first_q + frame_byte_i;

  assign lane_lon = p_eff - PosW'(OffLon);
  assign lane_lat = p_eff - PosW'(OffLat);
  assign lane_alt = p_eff - PosW'(OffAlt);
  assign lane_spd = p_eff - PosW'(OffSpeed);
  assign lane_hdg = p_eff - PosW'(OffHeading);

  always_comb begin
    pos_d = pos_q;
    if (take) begin
      pos_d = p_eff + PosW'(1);
    end else if (accept) begin
      pos_d = p_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_on_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        rx_on_q <= cfg_wdata_i;
      end
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (p_eff == '0) begin
        sum_first_q  <= '0;
        sum_second_q <= '0;
      end else if ((p_eff >= PosW'(SumFirstPos)) && (p_eff <= PosW'(SumLastPos))) begin
        sum_first_q  <= first_new;
        sum_second_q <= sum_second_q + first_new;
      end
      if (p_eff == PosW'(OffMonth))   small_q[0] <= frame_byte_i;
      if (p_eff == PosW'(OffDay))     small_q[1] <= frame_byte_i;
      if (p_eff == PosW'(OffHour))    small_q[2] <= frame_byte_i;
      if (p_eff == PosW'(OffMinute))  small_q[3] <= frame_byte_i;
      if (p_eff == PosW'(OffSecond))  small_q[4] <= frame_byte_i;
      if (p_eff == PosW'(OffValid))   small_q[5] <= {4'b0000, frame_byte_i[3:0]};
      if (p_eff == PosW'(OffFixType)) small_q[6] <= frame_byte_i;
      if (p_eff == PosW'(OffSats))    small_q[7] <= frame_byte_i;
      if (p_eff == PosW'(OffDopLo))   dop_q[7:0]  <= frame_byte_i;
      if (p_eff == PosW'(OffDopHi))   dop_q[15:8] <= frame_byte_i;
      if (p_eff == PosW'(OffTrailer)) trailer_q   <= frame_byte_i;
      if (in_word(p_eff, OffLon))     lon_q[{lane_lon[1:0], 3'b000} +: 8] <= frame_byte_i;
      if (in_word(p_eff, OffLat))     lat_q[{lane_lat[1:0], 3'b000} +: 8] <= frame_byte_i;
      if (in_word(p_eff, OffAlt))     alt_q[{lane_alt[1:0], 3'b000} +: 8] <= frame_byte_i;
      if (in_word(p_eff, OffSpeed))   spd_q[{lane_spd[1:0], 3'b000} +: 8] <= frame_byte_i;
      if (in_word(p_eff, OffHeading)) hdg_q[{lane_hdg[1:0], 3'b000} +: 8] <= frame_byte_i;
    end
  end

  always_comb begin
    frame_o.octets  = small_q;
    frame_o.lon     = lon_q;
    frame_o.lat     = lat_q;
    frame_o.alt     = alt_q;
    frame_o.speed   = spd_q;
    frame_o.heading = hdg_q;
    frame_o.dop     = dop_q;
    frame_o.good    = (sum_first_q == trailer_q) && (sum_second_q == frame_byte_i);
  end

  a_pos_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (pos_q == PosW'(FrameLen)))
    else $error("Position did not stop after the final byte.");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(FrameLen))
    else $error("Byte position ran past the frame length.");

endmodule

### hdl/nvp_scale.sv
// ----------------------------------------------------------------------------
// nvp_scale
// Two-stage pipeline that snapshots a finished frame and scales its fields.
// ----------------------------------------------------------------------------
module nvp_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               done_i,
  input  nvp_pkg::frame_t    frame_i,
  output logic               busy_o,
  output logic               load_o,
  output nvp_pkg::result_t   result_o
);
  import nvp_pkg::*;

  logic                      s1_v_q, s2_v_q;
  logic [ValW-1:0]           alt_mag, spd_mag, hdg_mag;
  logic [NumSmall-1:0][7:0]  small1_q, small2_q;
  logic [ValW-1:0]           lon1_q, lat1_q, lon2_q, lat2_q;
  logic                      good1_q, good2_q;
  logic                      alt_neg1_q, spd_neg1_q, hdg_neg1_q;
  logic                      alt_neg2_q, spd_neg2_q, hdg_neg2_q;
  logic [KiloNW-1:0]         alt_n_q, spd_n_q;
  logic [HdgNW-1:0]          hdg_n_q;
  logic [DopNW-1:0]          dop_n_q;
  logic [KiloNW+KiloMulW-1:0] alt_p_q, spd_p_q;
  logic [HdgNW+HdgMulW-1:0]  hdg_p_q;
  logic [DopNW+DopMulW-1:0]  dop_p_q;
  logic [ValW-1:0]           alt_q, spd_q, hdg_q, dop_q;

  assign alt_mag = frame_i.alt[ValW-1]     ? (ValW'(0) - frame_i.alt)     : frame_i.alt;
  assign spd_mag = frame_i.speed[ValW-1]   ? (ValW'(0) - frame_i.speed)   : frame_i.speed;
  assign hdg_mag = frame_i.heading[ValW-1] ? (ValW'(0) - frame_i.heading) : frame_i.heading;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= done_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_i) begin
      small1_q   <= frame_i.octets;
      lon1_q     <= frame_i.lon;
      lat1_q     <= frame_i.lat;
      good1_q    <= frame_i.good;
      alt_neg1_q <= frame_i.alt[ValW-1];
      spd_neg1_q <= frame_i.speed[ValW-1];
      hdg_neg1_q <= frame_i.heading[ValW-1];
      alt_n_q    <= alt_mag[ValW-1:KiloShift];
      spd_n_q    <= spd_mag[ValW-1:KiloShift];
      hdg_n_q    <= hdg_mag[ValW-1:HdgShift];
      dop_n_q    <= frame_i.dop[DopW-1:DopShift];
    end
    if (s1_v_q) begin
      small2_q   <= small1_q;
      lon2_q     <= lon1_q;
      lat2_q     <= lat1_q;
      good2_q    <= good1_q;
      alt_neg2_q <= alt_neg1_q;
      spd_neg2_q <= spd_neg1_q;
      hdg_neg2_q <= hdg_neg1_q;
      alt_p_q    <= (KiloNW+KiloMulW)'(alt_n_q) * (KiloNW+KiloMulW)'(KiloMul);
      spd_p_q    <= (KiloNW+KiloMulW)'(spd_n_q) * (KiloNW+KiloMulW)'(KiloMul);
      hdg_p_q    <= (HdgNW+HdgMulW)'(hdg_n_q) * (HdgNW+HdgMulW)'(HdgMul);
      dop_p_q    <= (DopNW+DopMulW)'(dop_n_q) * (DopNW+DopMulW)'(DopMul);
    end
  end

  always_comb begin
    alt_q = ValW'(alt_p_q[KiloNW+KiloMulW-1:KiloK]);
    spd_q = ValW'(spd_p_q[KiloNW+KiloMulW-1:KiloK]);
    hdg_q = ValW'(hdg_p_q[HdgNW+HdgMulW-1:HdgK]);
    dop_q = ValW'(dop_p_q[DopNW+DopMulW-1:DopK]);
    if (alt_neg2_q) alt_q = ValW'(0) - alt_q;
    if (spd_neg2_q) spd_q = ValW'(0) - spd_q;
    if (hdg_neg2_q) hdg_q = ValW'(0) - hdg_q;

    result_o.vals[FldMonth]   = ValW'(small2_q[0]);
    result_o.vals[FldDay]     = ValW'(small2_q[1]);
    result_o.vals[FldHour]    = ValW'(small2_q[2]);
    result_o.vals[FldMinute]  = ValW'(small2_q[3]);
    result_o.vals[FldSecond]  = ValW'(small2_q[4]);
    result_o.vals[FldValid]   = ValW'(small2_q[5]);
    result_o.vals[FldFixType] = ValW'(small2_q[6]);
    result_o.vals[FldSats]    = ValW'(small2_q[7]);
    result_o.vals[FldLon]     = lon2_q;
    result_o.vals[FldLat]     = lat2_q;
    result_o.vals[FldAlt]     = alt_q;
    result_o.vals[FldSpeed]   = spd_q;
    result_o.vals[FldDop]     = dop_q;
    result_o.vals[FldHeading] = hdg_q;
    result_o.good             = good2_q;
  end

  assign busy_o = s1_v_q || s2_v_q;
  assign load_o = s2_v_q;

endmodule

### hdl/nvp_emit.sv
// ----------------------------------------------------------------------------
// nvp_emit
// Result bank that hands out the fourteen fields of a frame one per transfer.
// ----------------------------------------------------------------------------
module nvp_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  nvp_pkg::result_t            result_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [nvp_pkg::CodeW-1:0]   field_code_o,
  output logic signed [nvp_pkg::ValW-1:0] field_value_o,
  output logic                        checksum_good_o,
  output logic                        last_field_o
);
  import nvp_pkg::*;

  logic                           valid_q;
  logic [CodeW-1:0]               idx_q;
  logic [NumFields-1:0][ValW-1:0] bank_q;
  logic                           good_q;
  logic                           xfer;

  assign xfer = valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load_i) begin
        valid_q <= 1'b1;
        idx_q   <= FldMonth;
      end else if (xfer) begin
        if (idx_q == FldHeading) begin
          valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + CodeW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bank_q <= result_i.vals;
      good_q <= result_i.good;
    end
  end

  assign busy_o          = valid_q;
  assign out_valid_o     = valid_q;
  assign field_code_o    = idx_q;
  assign field_value_o   = bank_q[idx_q];
  assign checksum_good_o = good_q;
  assign last_field_o    = (idx_q == FldHeading);

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !valid_q)
    else $error("Result bank loaded while a frame was still being sent.");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_field_o) |=> !out_valid_o)
    else $error("Output stayed valid after the final field transfer.");

endmodule

### hdl/ubx_nav_pvt_frame_parser_top.sv
// ----------------------------------------------------------------------------
// ubx_nav_pvt_frame_parser_top
// Parses 100-byte position-fix frames and emits fourteen decoded fields.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   frame_byte_i, frame_start_i
// out       output     out_valid_o / out_ready_i field_code_o, field_value_o,
//                                                checksum_good_o, last_field_o
// cfg       input      cfg_we_i                  cfg_wdata_i (receiver on)
//
// One byte is taken per cycle while in_ready_o is high. The fields of a
// frame leave one per transfer, after the two-stage scaling pipeline
// (snapshot, reciprocal multiply) and the result bank. The final byte of
// the next frame waits while the previous frame's fields are not all
// taken. Reset clears the byte position, the receiver-on register and all
// valid flags.
// ----------------------------------------------------------------------------
module ubx_nav_pvt_frame_parser_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      frame_byte_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [nvp_pkg::CodeW-1:0]       field_code_o,
  output logic signed [nvp_pkg::ValW-1:0] field_value_o,
  output logic                            checksum_good_o,
  output logic                            last_field_o
);
  import nvp_pkg::*;

  frame_t  frame;
  result_t result;
  logic    done, scale_busy, emit_busy, load;

  nvp_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_byte_i  (frame_byte_i),
    .frame_start_i (frame_start_i),
    .hold_i        (scale_busy || emit_busy),
    .done_o        (done),
    .frame_o       (frame)
  );

  nvp_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .done_i   (done),
    .frame_i  (frame),
    .busy_o   (scale_busy),
    .load_o   (load),
    .result_o (result)
  );

  nvp_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .result_i        (result),
    .busy_o          (emit_busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .field_code_o    (field_code_o),
    .field_value_o   (field_value_o),
    .checksum_good_o (checksum_good_o),
    .last_field_o    (last_field_o)
  );

endmodule

### sim/ubx_nav_pvt_frame_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_nav_pvt_frame_parser_top_tb
// Sends position-fix frames byte by byte with random gaps on both channels.
// A local decoder tracks the byte position, the Fletcher sums and the
// captured fields, queues the fourteen expected fields of every finished
// frame and compares them with each output transfer. Tests cover field
// extremes, checksum faults, restarts, bytes past the end, receiver power
// and output back-pressure.
// ----------------------------------------------------------------------------
module ubx_nav_pvt_frame_parser_top_tb;
  import nvp_pkg::*;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [ValW-1:0]  value;
    logic             good;
    logic             final_fld;
  } pvt_field_t;

  typedef enum int {SumOk, SumBadFirst, SumBadSecond} sum_fault_e;

  localparam int SettleCycles = 24;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [7:0]             frame_byte_i;
  logic                   frame_start_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [CodeW-1:0]       field_code_o;
  logic signed [ValW-1:0] field_value_o;
  logic                   checksum_good_o;
  logic                   last_field_o;

  pvt_field_t  fields_due[$];
  int          mismatch_count = 0;
  int          in_gap_max = 6;
  int          rx_gap_max = 6;
  int          stall_request = 0;
  int          stall_left = 0;
  int          pause_left = 0;
  logic [7:0]  frame_buf [FrameLen];
  int unsigned small_offs [NumSmall] = '{OffMonth, OffDay, OffHour, OffMinute,
                                         OffSecond, OffValid, OffFixType, OffSats};

  logic             receiver_on = 1'b0;
  logic [PosW-1:0]  nav_pos = '0;
  logic [7:0]       sum_a = '0;
  logic [7:0]       sum_b = '0;
  logic [7:0]       trail_a = '0;
  logic [7:0]       small_f [NumSmall] = '{default: '0};
  logic [ValW-1:0]  lon_w = '0;
  logic [ValW-1:0]  lat_w = '0;
  logic [ValW-1:0]  alt_w = '0;
  logic [ValW-1:0]  speed_w = '0;
  logic [ValW-1:0]  hdg_w = '0;
  logic [DopW-1:0]  dop_w = '0;

  ubx_nav_pvt_frame_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .frame_byte_i    (frame_byte_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .field_code_o    (field_code_o),
    .field_value_o   (field_value_o),
    .checksum_good_o (checksum_good_o),
    .last_field_o    (last_field_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void decode_frame_byte(input logic [7:0] b, input logic s);
    int unsigned     p;
    logic [ValW-1:0] vals [NumFields];
    logic            good;
    pvt_field_t      f;
    if (!receiver_on) return;
    if (s) nav_pos = '0;
    p = nav_pos;
    if (p >= FrameLen) return;
    if (p == 0) begin
      sum_a = '0;
      sum_b = '0;
    end
    if (p >= SumFirstPos && p <= SumLastPos) begin
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    end
    case (p)
      OffMonth:   small_f[0] = b;
      OffDay:     small_f[1] = b;
      OffHour:    small_f[2] = b;
      OffMinute:  small_f[3] = b;
      OffSecond:  small_f[4] = b;
      OffValid:   small_f[5] = {4'h0, b[3:0]};
      OffFixType: small_f[6] = b;
      OffSats:    small_f[7] = b;
      OffDopLo:   dop_w[7:0] = b;
      OffDopHi:   dop_w[15:8] = b;
      OffTrailer: trail_a = b;
      default: ;
    endcase
    if (p >= OffLon && p < OffLon + 4) lon_w[8*(p-OffLon) +: 8] = b;
    if (p >= OffLat && p < OffLat + 4) lat_w[8*(p-OffLat) +: 8] = b;
    if (p >= OffAlt && p < OffAlt + 4) alt_w[8*(p-OffAlt) +: 8] = b;
    if (p >= OffSpeed && p < OffSpeed + 4) speed_w[8*(p-OffSpeed) +: 8] = b;
    if (p >= OffHeading && p < OffHeading + 4) hdg_w[8*(p-OffHeading) +: 8] = b;
    nav_pos = PosW'(p + 1);
    if (p != LastPos) return;
    good = (sum_a == trail_a) && (sum_b == b);
    for (int k = 0; k < NumSmall; k++) vals[k] = {24'h0, small_f[k]};
    vals[FldLon]     = lon_w;
    vals[FldLat]     = lat_w;
    vals[FldAlt]     = $signed(alt_w) / 1000;
    vals[FldSpeed]   = $signed(speed_w) / 1000;
    vals[FldDop]     = {16'h0, dop_w} / 100;
    vals[FldHeading] = $signed(hdg_w) / 100000;
    for (int k = 0; k < NumFields; k++) begin
      f.code      = CodeW'(k);
      f.value     = vals[k];
      f.good      = good;
      f.final_fld = (f.code == FldHeading);
      fields_due.push_back(f);
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [ValW-1:0] want,
                               input logic [ValW-1:0] got);
    $display("%0t ns: %s expected %0d, got %0d", $time, what, $signed(want), $signed(got));
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    pvt_field_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fields_due.size() == 0) begin
        $display("%0t ns: no field expected, got code %0d value %0d", $time,
                 field_code_o, field_value_o);
        mismatch_count++;
      end else begin
        want = fields_due.pop_front();
        if (field_code_o !== want.code)
          note_mismatch("field code", want.code, field_code_o);
        if (field_value_o !== want.value)
          note_mismatch("field value", want.value, field_value_o);
        if (checksum_good_o !== want.good)
          note_mismatch("checksum flag", want.good, checksum_good_o);
        if (last_field_o !== want.final_fld)
          note_mismatch("last field flag", want.final_fld, last_field_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (pause_left > 0) begin
      pause_left--;
      out_ready_i <= (pause_left == 0);
    end else if (out_valid_o && out_ready_i) begin
      pause_left = $urandom_range(0, rx_gap_max);
      out_ready_i <= (pause_left == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    frame_byte_i  <= b;
    frame_start_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    decode_frame_byte(b, s);
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) send_byte(8'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_receiver(input logic on);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    receiver_on = on;
  endtask

  function automatic void fill_frame();
    for (int i = 0; i < FrameLen; i++) frame_buf[i] = 8'($urandom);
  endfunction

  function automatic void put_word(input int unsigned off, input logic [ValW-1:0] w);
    for (int i = 0; i < 4; i++) frame_buf[off+i] = w[8*i +: 8];
  endfunction

  function automatic void fill_small(input logic [7:0] v);
    for (int i = 0; i < NumSmall; i++) frame_buf[small_offs[i]] = v;
  endfunction

  function automatic logic [ValW-1:0] pick_word();
    logic [ValW-1:0] w;
    case ($urandom_range(0, 5))
      0: w = 32'h8000_0000;
      1: w = 32'h7FFF_FFFF;
      2: w = 32'h0;
      3: w = 32'hFFFF_FFFF;
      4: w = $urandom_range(0, 400000) - 200000;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic void seal_frame(input sum_fault_e fault);
    logic [7:0] a = '0;
    logic [7:0] c = '0;
    for (int i = SumFirstPos; i <= SumLastPos; i++) begin
      a = a + frame_buf[i];
      c = c + a;
    end
    frame_buf[OffTrailer] = a;
    frame_buf[LastPos]    = c;
    if (fault == SumBadFirst) frame_buf[OffTrailer] ^= 8'(1 << $urandom_range(0, 7));
    if (fault == SumBadSecond) frame_buf[LastPos] ^= 8'(1 << $urandom_range(0, 7));
  endfunction

  function automatic void random_frame(input sum_fault_e fault);
    fill_frame();
    put_word(OffLon, pick_word());
    put_word(OffLat, pick_word());
    put_word(OffAlt, pick_word());
    put_word(OffSpeed, pick_word());
    put_word(OffHeading, pick_word());
    seal_frame(fault);
  endfunction

  task automatic send_frame_part(input int first, input int stop, input logic start_first);
    for (int i = first; i <= stop; i++)
      send_byte(frame_buf[i], start_first && (i == first));
  endtask

  task automatic test_power_up_idle();
    send_noise(4);
    set_receiver(1'b1);
  endtask

  task automatic test_field_extremes();
    fill_frame();
    fill_small(8'hFF);
    put_word(OffLon, 32'hFFFF_FFFF);
    put_word(OffLat, 32'h8000_0000);
    put_word(OffAlt, 32'h8000_0000);
    put_word(OffSpeed, 32'h7FFF_FFFF);
    put_word(OffHeading, 32'h8000_0000);
    frame_buf[OffDopLo] = 8'hFF;
    frame_buf[OffDopHi] = 8'hFF;
    seal_frame(SumOk);
    // The first frame after reset carries no start flag.
    send_frame_part(0, LastPos, 1'b0);
    for (int i = 0; i < 3; i++) send_byte(8'($urandom), 1'b0);
    wait_drained();
  endtask

  task automatic test_restart_and_power_gap();
    random_frame(SumOk);
    send_frame_part(0, 9, 1'b1);
    random_frame(SumBadSecond);
    send_frame_part(0, 49, 1'b1);
    set_receiver(1'b0);
    send_noise(4);
    set_receiver(1'b1);
    send_frame_part(50, LastPos, 1'b0);
  endtask

  task automatic test_output_stall();
    // The fields of the previous frame are still queued, so the held
    // output backs up into the input at the final byte of this frame.
    in_gap_max = 0;
    stall_request = 400;
    fill_frame();
    fill_small(8'h00);
    frame_buf[OffValid] = 8'hF0;
    put_word(OffLon, 32'h0);
    put_word(OffLat, 32'h7FFF_FFFF);
    put_word(OffAlt, 32'h7FFF_FFFF);
    put_word(OffSpeed, 32'h8000_0000);
    put_word(OffHeading, 32'h7FFF_FFFF);
    frame_buf[OffDopLo] = 8'h00;
    frame_buf[OffDopHi] = 8'h00;
    seal_frame(SumBadFirst);
    send_frame_part(0, LastPos, 1'b1);
    wait_drained();
    in_gap_max = 6;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    in_valid_i    = 1'b0;
    frame_byte_i  = 8'h00;
    frame_start_i = 1'b0;
    out_ready_i   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_up_idle();
    test_field_extremes();
    test_restart_and_power_gap();
    test_output_stall();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS ubx_nav_pvt_frame_parser_top");
    end else begin
      $display("FAIL ubx_nav_pvt_frame_parser_top");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("FAIL ubx_nav_pvt_frame_parser_top");
    $finish;
  end

endmodule
